>>> src/mct_pkg.sv
// Shared types and constants for the multi-channel compare timer.
// Field widths, operation and unit codes, and millisecond conversion constants.
// No dependencies.
package mct_pkg;

   localparam int OP_BITS     = 2;
   localparam int CHAN_BITS   = 2;
   localparam int AMOUNT_BITS = 24;
   localparam int UNIT_BITS   = 2;
   localparam int FIRED_BITS  = 3;
   localparam int COUNT_BITS  = 24;

   localparam logic [OP_BITS-1:0] OP_TICK         = 2'd0;
   localparam logic [OP_BITS-1:0] OP_ARM_PERIODIC = 2'd1;
   localparam logic [OP_BITS-1:0] OP_ARM_SINGLE   = 2'd2;
   localparam logic [OP_BITS-1:0] OP_DELAY        = 2'd3;

   localparam logic [UNIT_BITS-1:0] UNIT_TICKS = 2'd0;
   localparam logic [UNIT_BITS-1:0] UNIT_MS    = 2'd1;
   localparam logic [UNIT_BITS-1:0] UNIT_SEC   = 2'd2;

   // Seconds: amount * 32768
   localparam int SEC_SHIFT = 15;

   // Milliseconds: ceil(amount * 4096 / 125), amount split in two halves
   localparam int MS_NUM     = 4096;
   localparam int MS_DEN     = 125;
   localparam int HALF_BITS  = AMOUNT_BITS / 2;
   localparam int MS_HI_Q    = ((2 ** HALF_BITS) * MS_NUM) / MS_DEN;
   localparam int MS_HI_R    = ((2 ** HALF_BITS) * MS_NUM) % MS_DEN;
   localparam int MS_LO_Q    = MS_NUM / MS_DEN;
   localparam int MS_LO_R    = MS_NUM % MS_DEN;
   localparam int MS_ROUND   = MS_DEN - 1;
   localparam int BASE_BITS  = 30;
   localparam int REM_BITS   = 20;

   // Remainder over 125 by reciprocal, exact for every remainder sum below 2^20
   localparam int RECIP_SHIFT = 27;
   localparam int RECIP_MUL   = ((2 ** RECIP_SHIFT) + MS_DEN - 1) / MS_DEN;
   localparam int RECIP_BITS  = 21;
   localparam int PROD_BITS   = REM_BITS + RECIP_BITS;

   localparam int WIDE_BITS = AMOUNT_BITS + SEC_SHIFT + 1;

   typedef struct packed {
      logic                 valid;
      logic [OP_BITS-1:0]   op;
      logic [CHAN_BITS-1:0] channel;
   } cmd_type;

endpackage

>>> src/mct_req_if.sv
// Request channel of the compare timer: valid/ready plus one command item.
// Depends on mct_pkg for field widths.
interface mct_req_if;
   logic                          valid;
   logic                          ready;
   logic [mct_pkg::OP_BITS-1:0]     op;
   logic [mct_pkg::CHAN_BITS-1:0]   channel;
   logic [mct_pkg::AMOUNT_BITS-1:0] amount;
   logic [mct_pkg::UNIT_BITS-1:0]   unit;

   modport source (output valid, op, channel, amount, unit, input ready);
   modport sink   (input valid, op, channel, amount, unit, output ready);
endinterface

>>> src/mct_rsp_if.sv
// Response channel of the compare timer: valid/ready plus one result item.
// Depends on mct_pkg for field widths.
interface mct_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [mct_pkg::FIRED_BITS-1:0] fired;
   logic                           delay_done;
   logic                           delay_busy;
   logic [mct_pkg::COUNT_BITS-1:0] count_now;

   modport source (output valid, fired, delay_done, delay_busy, count_now, input ready);
   modport sink   (input valid, fired, delay_done, delay_busy, count_now, output ready);
endinterface

>>> src/multi_channel_compare_timer.sv
// Top level of the multi-channel compare timer.
// Depends on mct_pkg, mct_req_if, mct_rsp_if, mct_convert and mct_engine.

// The block takes one request beat per clock cycle unless a stalled response
// holds it, and returns exactly one response beat for each, in order. A request
// either counts one tick, arms a callback channel (periodic or one-shot) or
// starts the delay channel; the amount is given in ticks, milliseconds
// (amount*4096/125 ticks, rounded up) or seconds (32768 ticks each). A request
// passes through the input register and two conversion stages before the
// execute stage updates the counter and the compare channels and registers its
// response. The rate of one beat per cycle is set by the execute stage, which
// does the counter increment, all channel compares and the compare reload
// together. A stalled response holds the pipe behind it; bubbles ahead of it
// still fill.
module multi_channel_compare_timer #(
   parameter int CALLBACK_CHANNELS = 3,
   parameter int COUNTER_BITS      = 24
) (
   input logic       clock,
   input logic       reset,
   mct_req_if.sink   req,
   mct_rsp_if.source rsp
);

   mct_pkg::cmd_type        cmd;
   logic [COUNTER_BITS-1:0] ticks;
   logic                    engine_ready;

   mct_convert #(
      .COUNTER_BITS (COUNTER_BITS)
   ) u_convert (
      .clock (clock),
      .reset (reset),
      .req   (req),
      .ready (engine_ready),
      .cmd   (cmd),
      .ticks (ticks)
   );

   mct_engine #(
      .CALLBACK_CHANNELS (CALLBACK_CHANNELS),
      .COUNTER_BITS      (COUNTER_BITS)
   ) u_engine (
      .clock (clock),
      .reset (reset),
      .cmd   (cmd),
      .ticks (ticks),
      .ready (engine_ready),
      .rsp   (rsp)
   );

endmodule

>>> src/mct_convert.sv
// Input register and two-stage unit conversion of the amount into ticks.
// Depends on mct_pkg and mct_req_if.
module mct_convert #(
   parameter int COUNTER_BITS = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   mct_req_if.sink                 req,
   input  logic                    ready,
   output mct_pkg::cmd_type        cmd,
   output logic [COUNTER_BITS-1:0] ticks
);

   // stage 0: input register
   logic                              v0_ff, v0_in;
   logic [mct_pkg::OP_BITS-1:0]       op0_ff;
   logic [mct_pkg::CHAN_BITS-1:0]     ch0_ff;
   logic [mct_pkg::AMOUNT_BITS-1:0]   amt0_ff;
   logic [mct_pkg::UNIT_BITS-1:0]     unit0_ff;

   // stage 1: split products
   logic                              v1_ff, v1_in;
   logic [mct_pkg::OP_BITS-1:0]       op1_ff;
   logic [mct_pkg::CHAN_BITS-1:0]     ch1_ff;
   logic [mct_pkg::AMOUNT_BITS-1:0]   amt1_ff;
   logic [mct_pkg::UNIT_BITS-1:0]     unit1_ff;
   logic [mct_pkg::BASE_BITS-1:0]     base1_ff, base_in;
   logic [mct_pkg::REM_BITS-1:0]      rem1_ff, rem_in;

   // stage 2: ticks
   logic                              v2_ff, v2_in;
   logic [mct_pkg::OP_BITS-1:0]       op2_ff;
   logic [mct_pkg::CHAN_BITS-1:0]     ch2_ff;
   logic [COUNTER_BITS-1:0]           ticks2_ff, ticks_in;

   logic                              ready0, ready1, ready2;
   logic [mct_pkg::HALF_BITS-1:0]     amt_hi, amt_lo;
   logic [mct_pkg::PROD_BITS-1:0]     recip_prod;
   logic [mct_pkg::BASE_BITS-1:0]     ms_ticks;
   logic [mct_pkg::WIDE_BITS-1:0]     wide_ticks;

   assign ready2    = !v2_ff || ready;
   assign ready1    = !v1_ff || ready2;
   assign ready0    = !v0_ff || ready1;
   assign req.ready = ready0;

   assign v0_in = ready0 ? req.valid : v0_ff;
   assign v1_in = ready1 ? v0_ff : v1_ff;
   assign v2_in = ready2 ? v1_ff : v2_ff;

   // amount*4096 + 124 = 125*(hi*MS_HI_Q + lo*MS_LO_Q) + (hi*MS_HI_R + lo*MS_LO_R + 124)
   always_comb begin
      amt_hi  = amt0_ff[mct_pkg::AMOUNT_BITS-1:mct_pkg::HALF_BITS];
      amt_lo  = amt0_ff[mct_pkg::HALF_BITS-1:0];
      base_in = mct_pkg::BASE_BITS'(amt_hi) * mct_pkg::BASE_BITS'(mct_pkg::MS_HI_Q)
              + mct_pkg::BASE_BITS'(amt_lo) * mct_pkg::BASE_BITS'(mct_pkg::MS_LO_Q);
      rem_in  = mct_pkg::REM_BITS'(amt_hi) * mct_pkg::REM_BITS'(mct_pkg::MS_HI_R)
              + mct_pkg::REM_BITS'(amt_lo) * mct_pkg::REM_BITS'(mct_pkg::MS_LO_R)
              + mct_pkg::REM_BITS'(mct_pkg::MS_ROUND);
   end

   always_comb begin
      recip_prod = mct_pkg::PROD_BITS'(rem1_ff) * mct_pkg::PROD_BITS'(mct_pkg::RECIP_MUL);
      ms_ticks   = base1_ff + mct_pkg::BASE_BITS'(
                      recip_prod[mct_pkg::PROD_BITS-1:mct_pkg::RECIP_SHIFT]);
      case (unit1_ff)
         mct_pkg::UNIT_MS: begin
            wide_ticks = mct_pkg::WIDE_BITS'(ms_ticks);
         end
         mct_pkg::UNIT_SEC: begin
            wide_ticks = mct_pkg::WIDE_BITS'(amt1_ff) << mct_pkg::SEC_SHIFT;
         end
         default: begin
            wide_ticks = mct_pkg::WIDE_BITS'(amt1_ff);
         end
      endcase
      ticks_in = wide_ticks[COUNTER_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= v0_in;
         v1_ff <= v1_in;
         v2_ff <= v2_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ready0 && req.valid) begin
         op0_ff   <= req.op;
         ch0_ff   <= req.channel;
         amt0_ff  <= req.amount;
         unit0_ff <= req.unit;
      end
      if (ready1 && v0_ff) begin
         op1_ff   <= op0_ff;
         ch1_ff   <= ch0_ff;
         amt1_ff  <= amt0_ff;
         unit1_ff <= unit0_ff;
         base1_ff <= base_in;
         rem1_ff  <= rem_in;
      end
      if (ready2 && v1_ff) begin
         op2_ff    <= op1_ff;
         ch2_ff    <= ch1_ff;
         ticks2_ff <= ticks_in;
      end
   end

   assign cmd.valid   = v2_ff;
   assign cmd.op      = op2_ff;
   assign cmd.channel = ch2_ff;
   assign ticks       = ticks2_ff;

endmodule

>>> src/mct_engine.sv
// Counter, compare channels, delay channel and the result register.
// Depends on mct_pkg and mct_rsp_if.
module mct_engine #(
   parameter int CALLBACK_CHANNELS = 3,
   parameter int COUNTER_BITS      = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  mct_pkg::cmd_type        cmd,
   input  logic [COUNTER_BITS-1:0] ticks,
   output logic                    ready,
   mct_rsp_if.source               rsp
);

   localparam int CW = COUNTER_BITS;
   localparam int NC = CALLBACK_CHANNELS;

   logic [CW-1:0]          count_ff, count_in;
   logic [NC-1:0][CW-1:0]  cmp_ff, cmp_in;
   logic [NC-1:0][CW-1:0]  period_ff, period_in;
   logic [CW-1:0]          delay_cmp_ff, delay_cmp_in;
   logic [NC-1:0]          enabled_ff, enabled_in;
   logic [NC-1:0]          single_ff, single_in;
   logic                   running_ff, running_in;

   logic                              rsp_valid_ff, rsp_valid_in;
   logic [mct_pkg::FIRED_BITS-1:0]    rsp_fired_ff, rsp_fired_in;
   logic                              rsp_done_ff, rsp_done_in;
   logic                              rsp_busy_ff;
   logic [mct_pkg::COUNT_BITS-1:0]    rsp_count_ff, rsp_count_in;

   logic                              fire;
   logic [CW-1:0]                     count_plus, arm_sum;
   logic [NC-1:0]                     hit;
   logic [NC+mct_pkg::FIRED_BITS-1:0] hit_ext;
   logic [CW+mct_pkg::COUNT_BITS-1:0] count_ext;

   assign ready        = !rsp_valid_ff || rsp.ready;
   assign fire         = cmd.valid && ready;
   assign rsp_valid_in = ready ? cmd.valid : rsp_valid_ff;
   assign count_plus   = count_ff + CW'(1);
   assign arm_sum      = count_ff + ticks;

   always_comb begin
      count_in     = count_ff;
      cmp_in       = cmp_ff;
      period_in    = period_ff;
      delay_cmp_in = delay_cmp_ff;
      enabled_in   = enabled_ff;
      single_in    = single_ff;
      running_in   = running_ff;
      hit          = '0;
      rsp_done_in  = 1'b0;
      if (fire) begin
         case (cmd.op)
            mct_pkg::OP_TICK: begin
               count_in = count_plus;
               if (running_ff && (delay_cmp_ff == count_plus)) begin
                  running_in  = 1'b0;
                  rsp_done_in = 1'b1;
               end
               for (int i = 0; i < NC; i++) begin
                  if (enabled_ff[i] && (cmp_ff[i] == count_plus)) begin
                     hit[i] = 1'b1;
                     if (single_ff[i]) begin
                        enabled_in[i] = 1'b0;
                     end else begin
                        cmp_in[i] = cmp_ff[i] + period_ff[i];
                     end
                  end
               end
            end
            mct_pkg::OP_DELAY: begin
               delay_cmp_in = arm_sum;
               running_in   = 1'b1;
            end
            default: begin
               // arm; a channel number past the last channel selects nothing
               for (int i = 0; i < NC; i++) begin
                  if (32'(cmd.channel) == i) begin
                     period_in[i]  = ticks;
                     single_in[i]  = (cmd.op == mct_pkg::OP_ARM_SINGLE);
                     enabled_in[i] = 1'b1;
                     cmp_in[i]     = arm_sum;
                  end
               end
            end
         endcase
      end
      hit_ext      = (NC + mct_pkg::FIRED_BITS)'(hit);
      rsp_fired_in = hit_ext[mct_pkg::FIRED_BITS-1:0];
      count_ext    = (CW + mct_pkg::COUNT_BITS)'(count_in);
      rsp_count_in = count_ext[mct_pkg::COUNT_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         enabled_ff   <= '0;
         single_ff    <= '0;
         running_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         enabled_ff   <= enabled_in;
         single_ff    <= single_in;
         running_ff   <= running_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // compare and period values are read only after an arm has written them
   always_ff @(posedge clock) begin
      cmp_ff       <= cmp_in;
      period_ff    <= period_in;
      delay_cmp_ff <= delay_cmp_in;
      if (fire) begin
         rsp_fired_ff <= rsp_fired_in;
         rsp_done_ff  <= rsp_done_in;
         rsp_busy_ff  <= running_in;
         rsp_count_ff <= rsp_count_in;
      end
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.fired      = rsp_fired_ff;
   assign rsp.delay_done = rsp_done_ff;
   assign rsp.delay_busy = rsp_busy_ff;
   assign rsp.count_now  = rsp_count_ff;

   a_nontick_quiet: assert property (@(posedge clock) disable iff (reset)
      (fire && (cmd.op != mct_pkg::OP_TICK)) |=>
         ($stable(count_ff) && (rsp_fired_ff == '0) && !rsp_done_ff))
      else $error("arm or delay beat moved the counter or reported a match");

   a_done_clears_busy: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_done_ff) |-> !rsp_busy_ff)
      else $error("delay reported done while still busy");

   a_tick_never_enables: assert property (@(posedge clock) disable iff (reset)
      (fire && (cmd.op == mct_pkg::OP_TICK)) |=>
         ((enabled_ff & ~$past(enabled_ff)) == '0))
      else $error("tick beat enabled a channel");

   a_delay_starts_busy: assert property (@(posedge clock) disable iff (reset)
      (fire && (cmd.op == mct_pkg::OP_DELAY)) |=> (running_ff && rsp_busy_ff))
      else $error("delay start did not set busy");

endmodule

>>> test/mct_timer_checker.sv
// Response checker for the multi-channel compare timer: predicts one result per request beat.
// Watches both channels passively and reports mismatches, outstanding count and totals.
// Depends on mct_pkg for field widths, operation codes, unit codes and conversion constants.
module mct_timer_checker #(
   parameter int CHANNELS = 3
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   input  logic                            req_ready,
   input  logic [mct_pkg::OP_BITS-1:0]     req_op,
   input  logic [mct_pkg::CHAN_BITS-1:0]   req_channel,
   input  logic [mct_pkg::AMOUNT_BITS-1:0] req_amount,
   input  logic [mct_pkg::UNIT_BITS-1:0]   req_unit,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [mct_pkg::FIRED_BITS-1:0]  rsp_fired,
   input  logic                            rsp_delay_done,
   input  logic                            rsp_delay_busy,
   input  logic [mct_pkg::COUNT_BITS-1:0]  rsp_count_now,
   output int                              fail_count,
   output int                              pending_count,
   output int                              checked_count,
   output int                              fire_events,
   output int                              delay_expiries
);

   typedef struct packed {
      logic [mct_pkg::FIRED_BITS-1:0] fired;
      logic                           delay_done;
      logic                           delay_busy;
      logic [mct_pkg::COUNT_BITS-1:0] count_now;
   } timer_outcome_type;

   logic [mct_pkg::COUNT_BITS-1:0] tick_now;
   logic [mct_pkg::COUNT_BITS-1:0] chan_cmp    [CHANNELS];
   logic [mct_pkg::COUNT_BITS-1:0] chan_period [CHANNELS];
   logic                           chan_on     [CHANNELS];
   logic                           chan_once   [CHANNELS];
   logic [mct_pkg::COUNT_BITS-1:0] delay_cmp;
   logic                           delay_active;

   timer_outcome_type queued_outcomes[$];
   timer_outcome_type want;
   int                fails;
   int                checked;
   int                fires;
   int                expiries;

   function automatic logic [mct_pkg::COUNT_BITS-1:0] amount_to_ticks(
      input logic [mct_pkg::AMOUNT_BITS-1:0] amt,
      input logic [mct_pkg::UNIT_BITS-1:0]   un
   );
      logic [63:0] wide;
      wide = {40'd0, amt};
      case (un)
         mct_pkg::UNIT_MS: begin
            wide = (wide * mct_pkg::MS_NUM + mct_pkg::MS_DEN - 1) / mct_pkg::MS_DEN;
         end
         mct_pkg::UNIT_SEC: begin
            wide = wide << mct_pkg::SEC_SHIFT;
         end
         default: begin
            wide = wide;
         end
      endcase
      return wide[mct_pkg::COUNT_BITS-1:0];
   endfunction

   // Advance the predicted timer state by one request and return its outcome.
   function automatic timer_outcome_type apply_request(
      input logic [mct_pkg::OP_BITS-1:0]     op,
      input logic [mct_pkg::CHAN_BITS-1:0]   ch,
      input logic [mct_pkg::AMOUNT_BITS-1:0] amt,
      input logic [mct_pkg::UNIT_BITS-1:0]   un
   );
      timer_outcome_type              res;
      logic [mct_pkg::COUNT_BITS-1:0] span;
      span = amount_to_ticks(amt, un);
      res = '0;
      case (op)
         mct_pkg::OP_TICK: begin
            tick_now = tick_now + 1'b1;
            if (delay_active && delay_cmp == tick_now) begin
               delay_active   = 1'b0;
               res.delay_done = 1'b1;
            end
            for (int i = 0; i < CHANNELS; i++) begin
               if (chan_on[i] && chan_cmp[i] == tick_now) begin
                  if (i < mct_pkg::FIRED_BITS) res.fired[i] = 1'b1;
                  if (chan_once[i]) chan_on[i] = 1'b0;
                  else chan_cmp[i] = chan_cmp[i] + chan_period[i];
               end
            end
         end
         mct_pkg::OP_DELAY: begin
            delay_cmp    = tick_now + span;
            delay_active = 1'b1;
         end
         default: begin
            // arms of a channel beyond the last one leave everything alone
            if (ch < CHANNELS) begin
               chan_period[ch] = span;
               chan_once[ch]   = (op == mct_pkg::OP_ARM_SINGLE);
               chan_on[ch]     = 1'b1;
               chan_cmp[ch]    = tick_now + span;
            end
         end
      endcase
      res.delay_busy = delay_active;
      res.count_now  = tick_now;
      return res;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         tick_now     = '0;
         delay_cmp    = '0;
         delay_active = 1'b0;
         for (int i = 0; i < CHANNELS; i++) begin
            chan_cmp[i]    = '0;
            chan_period[i] = '0;
            chan_on[i]     = 1'b0;
            chan_once[i]   = 1'b0;
         end
         queued_outcomes.delete();
         fails    = 0;
         checked  = 0;
         fires    = 0;
         expiries = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            fires    += $countones(rsp_fired);
            expiries += rsp_delay_done;
            if (queued_outcomes.size() == 0) begin
               $error("response beat with nothing outstanding: count_now %0h", rsp_count_now);
               fails++;
            end else begin
               want = queued_outcomes.pop_front();
               checked++;
               if (rsp_fired !== want.fired) begin
                  $error("fired: expected %0h, got %0h", want.fired, rsp_fired);
                  fails++;
               end
               if (rsp_delay_done !== want.delay_done) begin
                  $error("delay_done: expected %0b, got %0b", want.delay_done, rsp_delay_done);
                  fails++;
               end
               if (rsp_delay_busy !== want.delay_busy) begin
                  $error("delay_busy: expected %0b, got %0b", want.delay_busy, rsp_delay_busy);
                  fails++;
               end
               if (rsp_count_now !== want.count_now) begin
                  $error("count_now: expected %0h, got %0h", want.count_now, rsp_count_now);
                  fails++;
               end
            end
         end
         if (req_valid && req_ready)
            queued_outcomes.push_back(apply_request(req_op, req_channel, req_amount, req_unit));
      end
      fail_count     <= fails;
      pending_count  <= queued_outcomes.size();
      checked_count  <= checked;
      fire_events    <= fires;
      delay_expiries <= expiries;
   end

endmodule

>>> test/multi_channel_compare_timer_tb.sv
// Testbench top for the multi-channel compare timer: clock, reset, request stimulus,
// response back-pressure and the verdict. Depends on mct_pkg, mct_req_if, mct_rsp_if,
// multi_channel_compare_timer and mct_timer_checker.
module multi_channel_compare_timer_tb;

   localparam logic [mct_pkg::UNIT_BITS-1:0] UNIT_SPARE = 2'd3;
   localparam logic [mct_pkg::CHAN_BITS-1:0] CHAN_NONE  = 2'd3;
   localparam int RANDOM_PER_PHASE = 342;
   localparam int LONG_HOLD_CYCLES = 64;
   localparam int DRAIN_CYCLES     = 12;

   logic clock;
   logic reset;
   int   send_idle_pct;
   int   recv_idle_pct;
   bit   long_hold_go;
   bit   long_hold_done;
   int   items_sent;
   int   fail_count;
   int   pending_count;
   int   checked_count;
   int   fire_events;
   int   delay_expiries;

   mct_req_if req_ch ();
   mct_rsp_if rsp_ch ();

   multi_channel_compare_timer DUT (
      .clock (clock),
      .reset (reset),
      .req   (req_ch),
      .rsp   (rsp_ch)
   );

   mct_timer_checker timer_watch (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_ch.valid),
      .req_ready      (req_ch.ready),
      .req_op         (req_ch.op),
      .req_channel    (req_ch.channel),
      .req_amount     (req_ch.amount),
      .req_unit       (req_ch.unit),
      .rsp_valid      (rsp_ch.valid),
      .rsp_ready      (rsp_ch.ready),
      .rsp_fired      (rsp_ch.fired),
      .rsp_delay_done (rsp_ch.delay_done),
      .rsp_delay_busy (rsp_ch.delay_busy),
      .rsp_count_now  (rsp_ch.count_now),
      .fail_count     (fail_count),
      .pending_count  (pending_count),
      .checked_count  (checked_count),
      .fire_events    (fire_events),
      .delay_expiries (delay_expiries)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #400000;
      $display("multi_channel_compare_timer regression: fail");
      $finish;
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      rsp_ch.ready   = 1'b0;
      long_hold_done = 1'b0;
      forever begin
         @(posedge clock);
         if (long_hold_go && !long_hold_done) begin
            long_hold_done = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (LONG_HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_beat(
      input logic [mct_pkg::OP_BITS-1:0]     op,
      input logic [mct_pkg::CHAN_BITS-1:0]   ch,
      input logic [mct_pkg::AMOUNT_BITS-1:0] amt,
      input logic [mct_pkg::UNIT_BITS-1:0]   un
   );
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.op      <= op;
      req_ch.channel <= ch;
      req_ch.amount  <= amt;
      req_ch.unit    <= un;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      items_sent++;
   endtask

   // Hold the request side until every outstanding response has come back.
   task automatic wait_drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_count != 0) @(posedge clock);
   endtask

   // Mostly ticks and short arms so channels fire often; a share of full-range noise.
   task automatic send_random();
      logic [mct_pkg::OP_BITS-1:0]     op;
      logic [mct_pkg::CHAN_BITS-1:0]   ch;
      logic [mct_pkg::AMOUNT_BITS-1:0] amt;
      logic [mct_pkg::UNIT_BITS-1:0]   un;
      int                              pick;
      pick = $urandom_range(99);
      if (pick < 58) op = mct_pkg::OP_TICK;
      else if (pick < 72) op = mct_pkg::OP_ARM_PERIODIC;
      else if (pick < 86) op = mct_pkg::OP_ARM_SINGLE;
      else op = mct_pkg::OP_DELAY;
      ch = ($urandom_range(9) == 0) ? CHAN_NONE : mct_pkg::CHAN_BITS'($urandom_range(2));
      pick = $urandom_range(99);
      if (pick < 70) begin
         un  = ($urandom_range(7) == 0) ? UNIT_SPARE : mct_pkg::UNIT_TICKS;
         amt = mct_pkg::AMOUNT_BITS'($urandom_range(24));
      end else if (pick < 82) begin
         un  = mct_pkg::UNIT_MS;
         amt = mct_pkg::AMOUNT_BITS'($urandom_range(1));
      end else if (pick < 88) begin
         un  = mct_pkg::UNIT_SEC;
         amt = mct_pkg::AMOUNT_BITS'($urandom());
      end else begin
         un  = mct_pkg::UNIT_BITS'($urandom_range(3));
         amt = mct_pkg::AMOUNT_BITS'($urandom());
      end
      send_beat(op, ch, amt, un);
   endtask

   task automatic run_phase(input int send_pct, input int recv_pct, input bit with_hold);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
      for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
         if (with_hold && n == 40) long_hold_go = 1'b1;
         send_random();
      end
      wait_drain();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.op      = mct_pkg::OP_TICK;
      req_ch.channel = '0;
      req_ch.amount  = '0;
      req_ch.unit    = mct_pkg::UNIT_TICKS;
      send_idle_pct  = 0;
      recv_idle_pct  = 0;
      long_hold_go   = 1'b0;
      items_sent     = 0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_ARM_PERIODIC, 2'd0,      24'd1,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_ARM_SINGLE,   2'd1,      24'd2,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_ARM_PERIODIC, CHAN_NONE, 24'd1,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_ARM_SINGLE,   CHAN_NONE, 24'd2,      mct_pkg::UNIT_MS);
      send_beat(mct_pkg::OP_ARM_SINGLE,   2'd2,      24'd3,      UNIT_SPARE);
      send_beat(mct_pkg::OP_DELAY,        2'd0,      24'd2,      mct_pkg::UNIT_TICKS);
      // restart while running: the newer compare wins
      send_beat(mct_pkg::OP_DELAY,        2'd0,      24'd1,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_ARM_PERIODIC, 2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_ARM_PERIODIC, 2'd1,      24'hFFFFFF, mct_pkg::UNIT_MS);
      send_beat(mct_pkg::OP_ARM_SINGLE,   2'd2,      24'hFFFFFF, mct_pkg::UNIT_SEC);
      send_beat(mct_pkg::OP_DELAY,        CHAN_NONE, 24'hFFFFFF, UNIT_SPARE);
      send_beat(mct_pkg::OP_DELAY,        2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      send_beat(mct_pkg::OP_ARM_PERIODIC, 2'd0,      24'd1,      mct_pkg::UNIT_MS);
      send_beat(mct_pkg::OP_TICK,         CHAN_NONE, 24'hFFFFFF, UNIT_SPARE);
      send_beat(mct_pkg::OP_ARM_SINGLE,   2'd1,      24'd1,      mct_pkg::UNIT_SEC);
      send_beat(mct_pkg::OP_TICK,         2'd0,      24'd0,      mct_pkg::UNIT_TICKS);
      wait_drain();

      run_phase(14, 72, 1'b0);
      run_phase(72, 14, 1'b0);
      run_phase(0, 0, 1'b1);

      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d request beats over directed, skewed and unthrottled traffic",
               items_sent);
      $display("checked %0d responses: %0d channel fires, %0d delay expiries",
               checked_count, fire_events, delay_expiries);
      if (fail_count == 0) begin
         $display("multi_channel_compare_timer regression: pass");
      end else begin
         $display("multi_channel_compare_timer regression: fail");
      end
      $finish;
   end

endmodule
